// File: design/brr_pkg.sv
// Package for the BRR ADPCM decoder: field widths, filter codes, header and sample math.
package brr_pkg;

  // Stream field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned SampleW = 16;
  localparam int unsigned OutUserW = 3;

  // Data bytes per block; position runs 1..BlockBytes
  localparam logic [3:0] BlockBytes = 4'd8;

  // First shift value whose result is forced to a fixed level
  localparam logic [3:0] ShiftClip = 4'd13;

  // Predictor selection from the header
  typedef enum logic [1:0] {
    FILT_NONE = 2'd0,
    FILT_P1   = 2'd1,
    FILT_P2   = 2'd2,
    FILT_P3   = 2'd3
  } brr_filter_e;

  // Decoded block header
  typedef struct packed {
    logic [3:0]  shift;
    brr_filter_e filter;
    logic        loop_flag;
    logic        end_flag;
  } brr_hdr_t;

  // One nibble through shift, clip, predictor, clamp and doubling
  function automatic logic [SampleW-1:0] brr_decode_nibble(
    input logic [3:0]         nib,
    input brr_hdr_t           hdr,
    input logic [SampleW-1:0] newer,
    input logic [SampleW-1:0] older
  );
    logic signed [16:0] nib_ext;
    logic signed [16:0] shifted;
    logic signed [16:0] base;
    logic signed [20:0] p1;
    logic signed [20:0] p2;
    logic signed [20:0] acc;
    logic [15:0]        clamped;
    nib_ext = {{13{nib[3]}}, nib};
    shifted = nib_ext <<< hdr.shift;
    base    = shifted >>> 1;
    if (hdr.shift >= ShiftClip) begin
      base = nib[3] ? -17'sd2048 : 17'sd0;
    end
    p1  = 21'(signed'(newer));
    p2  = 21'(signed'(older)) >>> 1;
    acc = 21'(base);
    case (hdr.filter)
      FILT_NONE: acc = acc;
      FILT_P1:   acc = acc + (p1 >>> 1) + ((-p1) >>> 5);
      FILT_P2:   acc = acc + p1 - p2 + (p2 >>> 4) + ((p1 * -21'sd3) >>> 6);
      FILT_P3:   acc = acc + p1 - p2 + ((p1 * -21'sd13) >>> 7) + ((p2 * 21'sd3) >>> 4);
      default:   acc = acc;
    endcase
    // clamp to 16 bits, then double with wrap
    if (acc > 21'sd32767) begin
      clamped = 16'h7FFF;
    end else if (acc < -21'sd32768) begin
      clamped = 16'h8000;
    end else begin
      clamped = acc[15:0];
    end
    return {clamped[14:0], 1'b0};
  endfunction

endpackage

// File: design/brr_adpcm_sample_decoder_top.sv
// Top level of the BRR ADPCM sample decoder: byte intake, nibble stage and output register.
//
// Bytes of a BRR stream enter on the slave stream: a header byte, then eight
// data bytes, repeated. tuser on the input is the restart flag, which clears
// the predictor history and takes the byte as a header. A header byte gives no
// output item; each data byte gives two samples, high nibble first, on the
// master stream, with tlast on the last sample of a block.
// A data byte waits in the nibble stage while its samples pass in turn to
// the output register. Throughput: one header byte per cycle while the stage
// is free; a data byte holds the stage until both samples have moved on, as the
// single nibble stage shares one predictor that needs the previous sample.
// A new byte is taken as the held byte's second sample moves to the output
// register, so data bytes sustain one sample per cycle when the receiver does not stall.
// Reset clears position, header and history: the first byte is a header.
// When the receiver stalls, the output register holds its item and the
// nibble stage holds its byte; input tready falls until the stage drains.
module brr_adpcm_sample_decoder_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [brr_pkg::ByteW-1:0]       s_axis_tdata_i,  // [7:0] block_byte
  input  logic                            s_axis_tuser_i,  // [0] restart
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [brr_pkg::SampleW-1:0]     m_axis_tdata_o,  // [15:0] pcm_sample
  output logic [brr_pkg::OutUserW-1:0]    m_axis_tuser_o,  // [0] pair_last, [1] block_end_flag,
                                                           // [2] block_loop_flag
  output logic                            m_axis_tlast_o   // block_done
);
  import brr_pkg::*;

  // Stream position and header
  logic [3:0]         pos_q, pos_d;
  brr_hdr_t           hdr_q, hdr_d;
  logic [SampleW-1:0] newer_q, newer_d;
  logic [SampleW-1:0] older_q, older_d;

  // Nibble stage
  logic               stg_valid_q, stg_valid_d;
  logic               stg_lo_q, stg_lo_d;
  logic [ByteW-1:0]   stg_byte_q, stg_byte_d;
  brr_hdr_t           stg_hdr_q, stg_hdr_d;
  logic               stg_done_q, stg_done_d;

  // Output register
  logic               out_valid_q, out_valid_d;
  logic [SampleW-1:0] out_sample_q, out_sample_d;
  logic               out_pair_q, out_pair_d;
  logic               out_end_q, out_end_d;
  logic               out_loop_q, out_loop_d;
  logic               out_last_q, out_last_d;

  logic               in_fire;
  logic               is_header;
  logic               stg_fire;
  logic [3:0]         cur_nib;
  logic [SampleW-1:0] sample;

  // Handshake
  assign stg_fire        = stg_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !stg_valid_q || (stg_lo_q && stg_fire);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign is_header       = s_axis_tuser_i || (pos_q == 4'd0) || (pos_q > BlockBytes);

  // Sample math for the current nibble
  assign cur_nib = stg_lo_q ? stg_byte_q[3:0] : stg_byte_q[7:4];
  assign sample  = brr_decode_nibble(cur_nib, stg_hdr_q, newer_q, older_q);

  always_comb begin
    pos_d        = pos_q;
    hdr_d        = hdr_q;
    newer_d      = newer_q;
    older_d      = older_q;
    stg_valid_d  = stg_valid_q;
    stg_lo_d     = stg_lo_q;
    stg_byte_d   = stg_byte_q;
    stg_hdr_d    = stg_hdr_q;
    stg_done_d   = stg_done_q;
    out_valid_d  = out_valid_q;
    out_sample_d = out_sample_q;
    out_pair_d   = out_pair_q;
    out_end_d    = out_end_q;
    out_loop_d   = out_loop_q;
    out_last_d   = out_last_q;

    // output drains
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    // one nibble moves to the output register and into history
    if (stg_fire) begin
      out_valid_d  = 1'b1;
      out_sample_d = sample;
      out_pair_d   = stg_lo_q;
      out_end_d    = stg_hdr_q.end_flag;
      out_loop_d   = stg_hdr_q.loop_flag;
      out_last_d   = stg_lo_q && stg_done_q;
      older_d      = newer_q;
      newer_d      = sample;
      if (stg_lo_q) begin
        stg_valid_d = 1'b0;
        stg_lo_d    = 1'b0;
      end else begin
        stg_lo_d = 1'b1;
      end
    end

    // byte intake; a restart clears history after any sample leaving now
    if (in_fire) begin
      if (is_header) begin
        hdr_d = brr_hdr_t'(s_axis_tdata_i);
        pos_d = 4'd1;
        if (s_axis_tuser_i) begin
          newer_d = '0;
          older_d = '0;
        end
      end else begin
        stg_valid_d = 1'b1;
        stg_lo_d    = 1'b0;
        stg_byte_d  = s_axis_tdata_i;
        stg_hdr_d   = hdr_q;
        stg_done_d  = (pos_q == BlockBytes);
        pos_d       = (pos_q == BlockBytes) ? 4'd0 : pos_q + 4'd1;
      end
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      hdr_q       <= '0;
      newer_q     <= '0;
      older_q     <= '0;
      stg_valid_q <= 1'b0;
      stg_lo_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      hdr_q       <= hdr_d;
      newer_q     <= newer_d;
      older_q     <= older_d;
      stg_valid_q <= stg_valid_d;
      stg_lo_q    <= stg_lo_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    stg_byte_q   <= stg_byte_d;
    stg_hdr_q    <= stg_hdr_d;
    stg_done_q   <= stg_done_d;
    out_sample_q <= out_sample_d;
    out_pair_q   <= out_pair_d;
    out_end_q    <= out_end_d;
    out_loop_q   <= out_loop_d;
    out_last_q   <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_sample_q;
  assign m_axis_tuser_o  = {out_loop_q, out_end_q, out_pair_q};
  assign m_axis_tlast_o  = out_last_q;

endmodule

// File: verif/tb.sv
// Testbench for the BRR ADPCM sample decoder: byte stream in, checked PCM samples out.
module tb;
  import brr_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned RandBytes  = 1000;
  localparam int unsigned HoldStart  = 300;
  localparam int unsigned HoldCycles = 200;

  // One byte waiting to be offered; drain holds it back until all samples are out
  typedef struct {
    logic [ByteW-1:0] data;
    logic             restart;
    logic             drain;
  } byte_item_t;

  // One decoded sample as it should leave the block
  typedef struct {
    logic [SampleW-1:0] pcm;
    logic               pair_last;
    logic               end_flag;
    logic               loop_flag;
    logic               done;
  } pcm_item_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_valid = 1'b0;
  logic               s_axis_tready_o;
  logic [ByteW-1:0]   s_data = '0;
  logic               s_user = 1'b0;
  logic               m_axis_tvalid_o;
  logic               m_ready = 1'b0;
  logic [SampleW-1:0] m_axis_tdata_o;
  logic [OutUserW-1:0] m_axis_tuser_o;
  logic               m_axis_tlast_o;

  byte_item_t byte_q[$];
  pcm_item_t  pcm_q[$];

  // Decoder state as predicted
  logic [3:0]         blk_pos = '0;
  brr_hdr_t           blk_hdr = '0;
  logic [SampleW-1:0] hist_newer = '0;
  logic [SampleW-1:0] hist_older = '0;

  int unsigned cycle_cnt = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned bytes_in = 0;
  int unsigned restarts_in = 0;
  int unsigned samples_out = 0;
  int unsigned blocks_out = 0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned pat_age = 0;
  logic [7:0]  ready_pat = 8'hFF;

  brr_adpcm_sample_decoder_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // One nibble: shift, clip at large shifts, predictor, clamp, double
  function automatic logic [SampleW-1:0] decode_nib(input logic [3:0] nib);
    int s;
    int p1;
    int p2;
    logic [SampleW-1:0] pcm;
    s  = nib[3] ? int'(nib) - 16 : int'(nib);
    s  = (s * (1 << blk_hdr.shift)) >>> 1;
    if (blk_hdr.shift >= ShiftClip) begin
      s = (s < 0) ? -2048 : 0;
    end
    p1 = $signed(hist_newer);
    p2 = int'($signed(hist_older)) >>> 1;
    case (blk_hdr.filter)
      FILT_P1: s = s + (p1 >>> 1) + ((-p1) >>> 5);
      FILT_P2: s = s + p1 - p2 + (p2 >>> 4) + ((p1 * -3) >>> 6);
      FILT_P3: s = s + p1 - p2 + ((p1 * -13) >>> 7) + ((p2 * 3) >>> 4);
      default: s = s;
    endcase
    if (s > 32767) begin
      s = 32767;
    end else if (s < -32768) begin
      s = -32768;
    end
    pcm = 16'(s * 2);
    hist_older = hist_newer;
    hist_newer = pcm;
    return pcm;
  endfunction

  // Advance the predicted decoder by one accepted byte, queue its samples
  function automatic void absorb_byte(input byte_item_t it);
    pcm_item_t smp;
    if (it.restart) begin
      hist_newer = '0;
      hist_older = '0;
    end
    if (it.restart || blk_pos == 0 || blk_pos > BlockBytes) begin
      blk_hdr = brr_hdr_t'(it.data);
      blk_pos = 4'd1;
    end else begin
      for (int k = 0; k < 2; k++) begin
        smp.pcm       = decode_nib((k == 0) ? it.data[7:4] : it.data[3:0]);
        smp.pair_last = (k == 1);
        smp.end_flag  = blk_hdr.end_flag;
        smp.loop_flag = blk_hdr.loop_flag;
        smp.done      = (k == 1) && (blk_pos == BlockBytes);
        pcm_q.push_back(smp);
      end
      blk_pos = (blk_pos == BlockBytes) ? 4'd0 : blk_pos + 4'd1;
    end
  endfunction

  function automatic int unsigned pick_gap();
    // a stretch in the middle runs back to back
    if (bytes_in >= 600 && bytes_in < 750) begin
      return 0;
    end
    case ($urandom_range(0, 5))
      0, 1:    return 0;
      2, 3:    return $urandom_range(1, 3);
      4:       return $urandom_range(4, 12);
      default: return $urandom_range(15, 40);
    endcase
  endfunction

  function automatic logic [ByteW-1:0] rand_data();
    logic [ByteW-1:0] corner [6] = '{8'h00, 8'hFF, 8'h7F, 8'h80, 8'h88, 8'h77};
    if ($urandom_range(0, 3) == 0) begin
      return corner[$urandom_range(0, 5)];
    end
    return 8'($urandom);
  endfunction

  task automatic push_byte(input logic [ByteW-1:0] data, input logic restart,
                           input logic drain);
    byte_item_t it;
    it.data    = data;
    it.restart = restart;
    it.drain   = drain;
    byte_q.push_back(it);
  endtask

  task automatic note_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("[%0d] MISMATCH: %s", cycle_cnt, msg);
    end
  endtask

  // Byte driver: bursts with random gaps, optional drain before an item
  always @(posedge clk_i) begin : drive_bytes
    logic took;
    took = s_valid && s_axis_tready_o;
    if (!rst_ni) begin
      s_valid <= 1'b0;
    end else begin
      if (took) begin
        absorb_byte(byte_q[0]);
        if (byte_q[0].restart) begin
          restarts_in++;
        end
        void'(byte_q.pop_front());
        bytes_in++;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = pick_gap();
        end else begin
          burst_left--;
        end
      end
      if (s_valid && !took) begin
        // hold the offered item
      end else if (gap_left > 0) begin
        gap_left--;
        s_valid <= 1'b0;
      end else if (byte_q.size() > 0 && !(byte_q[0].drain && pcm_q.size() != 0)) begin
        s_valid <= 1'b1;
        s_data  <= byte_q[0].data;
        s_user  <= byte_q[0].restart;
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, once, while bytes keep coming
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (!hold_done && bytes_in >= HoldStart) begin
        hold_left <= HoldCycles;
        hold_done <= 1'b1;
      end
    end
  end

  // Receiver ready: rotating stall pattern, renewed now and then
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (pat_age == 0) begin
        ready_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
        pat_age   = $urandom_range(20, 80);
      end else begin
        pat_age--;
      end
      ready_pat = {ready_pat[6:0], ready_pat[7]};
      m_ready <= (hold_left == 0) && ready_pat[0];
    end
  end

  // Sample checker
  always @(posedge clk_i) begin : check_samples
    pcm_item_t want;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      samples_out++;
      if (m_axis_tlast_o) begin
        blocks_out++;
      end
      if (pcm_q.size() == 0) begin
        note_mismatch($sformatf("unexpected sample pcm=%h user=%b last=%b",
                                m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o));
      end else begin
        want = pcm_q.pop_front();
        if (m_axis_tdata_o !== want.pcm || m_axis_tuser_o[0] !== want.pair_last ||
            m_axis_tuser_o[1] !== want.end_flag || m_axis_tuser_o[2] !== want.loop_flag ||
            m_axis_tlast_o !== want.done) begin
          note_mismatch($sformatf(
            "exp pcm=%h pair=%b end=%b loop=%b done=%b, got pcm=%h pair=%b end=%b loop=%b done=%b",
            want.pcm, want.pair_last, want.end_flag, want.loop_flag, want.done,
            m_axis_tdata_o, m_axis_tuser_o[0], m_axis_tuser_o[1], m_axis_tuser_o[2],
            m_axis_tlast_o));
        end
      end
    end
  end

  // Watchdog
  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("Timeout after %0d cycles, %0d samples still expected", cycle_cnt, pcm_q.size());
    $display("Some tests failed");
    $finish;
  end

  // Stimulus, reset and end of run
  initial begin
    logic [ByteW-1:0] corner [8] = '{8'h00, 8'hFF, 8'h7F, 8'h80, 8'h88, 8'h77, 8'h08, 8'hF0};
    logic [ByteW-1:0] sat [8] = '{8'h7F, 8'h80, 8'h7F, 8'h80, 8'h77, 8'h88, 8'hF7, 8'h17};
    int unsigned blk_len;
    bit          need_restart;
    bit          drain_set;

    // plain block, no shift, no predictor, nibble extremes
    push_byte(8'h00, 1'b0, 1'b0);
    foreach (corner[i]) push_byte(corner[i], 1'b0, 1'b0);
    // restart at a block boundary; shift 12, first predictor, both flags
    push_byte(8'hC7, 1'b1, 1'b0);
    push_byte(8'h7F, 1'b0, 1'b0);
    push_byte(8'h7F, 1'b0, 1'b0);
    push_byte(8'h77, 1'b0, 1'b0);
    // restart; shift 13 clips, second predictor, loop flag
    push_byte(8'hDA, 1'b1, 1'b0);
    push_byte(8'h80, 1'b0, 1'b0);
    push_byte(8'h7F, 1'b0, 1'b0);
    push_byte(8'h08, 1'b0, 1'b0);
    // restart; shift 15, third predictor, end flag, full block
    push_byte(8'hFD, 1'b1, 1'b0);
    foreach (sat[i]) push_byte(sat[i], 1'b0, 1'b0);

    // mostly whole blocks; some cut short, some stray restarts
    need_restart = 1'b0;
    drain_set    = 1'b0;
    while (byte_q.size() < RandBytes) begin
      blk_len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : 8;
      push_byte(8'($urandom), need_restart || ($urandom_range(0, 7) == 0),
                !drain_set && byte_q.size() >= RandBytes / 2);
      if (byte_q.size() >= RandBytes / 2) begin
        drain_set = 1'b1;
      end
      need_restart = (blk_len < 8);
      for (int i = 0; i < blk_len; i++) begin
        if ($urandom_range(0, 63) == 0) begin
          push_byte(rand_data(), 1'b1, 1'b0);
          need_restart = 1'b1;
        end else begin
          push_byte(rand_data(), 1'b0, 1'b0);
        end
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (byte_q.size() > 0 || s_valid || pcm_q.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);

    if (pcm_q.size() != 0) begin
      note_mismatch($sformatf("%0d samples never arrived", pcm_q.size()));
    end
    $display("Fed %0d bytes (%0d with restart), checked %0d samples over %0d finished blocks",
             bytes_in, restarts_in, samples_out, blocks_out);
    $display("Mismatches: %0d, cycles: %0d", mismatch_cnt, cycle_cnt);
    if (mismatch_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
